### src/oaht_pkg.sv
// Shared types and constants for the open-addressing hash table.
// Used by oaht_mod, open_addressing_hash_table and oaht_checker; no dependencies.
package oaht_pkg;

	localparam int KEY_W     = 31;
	localparam int SIZE_W    = 6;
	localparam int SLOT_W    = 5;
	localparam int CFG_IDX_W = 1;

	// Item actions
	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_LOOKUP = 2'd2,
		ACT_DELETE = 2'd3
	} action_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_FULL     = 3'd1,
		ST_FOUND    = 3'd2,
		ST_MISSING  = 3'd3,
		ST_DELETED  = 3'd4,
		ST_CLEARED  = 3'd5
	} status_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = 1'b1;

	// Request to the remainder unit
	typedef struct packed {
		logic              start;
		logic [KEY_W-1:0]  key;
		logic [SIZE_W-1:0] size;
	} mod_req_t;

	// Response from the remainder unit
	typedef struct packed {
		logic              done;
		logic [SIZE_W-1:0] rem;
	} mod_rsp_t;

endpackage

### src/oaht_mod.sv
// Bit-serial remainder unit: key mod size, one key bit per cycle.
// Depends on oaht_pkg.
module oaht_mod import oaht_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mod_req_t req,
	output mod_rsp_t rsp
);

	localparam int CNT_W = $clog2(KEY_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SIZE_W-1:0] rem_q;
	logic [KEY_W-1:0]  dv_q;
	logic [SIZE_W:0]   trial;
	logic [SIZE_W:0]   trial_sub;

	// Shift in the next key bit and subtract the divisor when it fits
	always_comb begin
		trial     = {rem_q, dv_q[KEY_W-1]};
		trial_sub = (trial >= {1'b0, req.size}) ? (trial - {1'b0, req.size}) : trial;
	end

	// Advance one remainder step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dv_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				dv_q   <= req.key;
			end else if (busy_q) begin
				rem_q <= trial_sub[SIZE_W-1:0];
				dv_q  <= {dv_q[KEY_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(KEY_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

### src/open_addressing_hash_table.sv
// Open-addressing hash table: clear, insert, lookup and delete of 31-bit keys.
// Depends on oaht_pkg and oaht_mod.
//
// The block takes one item at a time and returns one result per item. Clear
// goes straight to the result hand-over. Insert first forms key mod size in a
// bit-serial remainder unit, then probes one slot per cycle, linearly or
// quadratically, over at most size slots, then hands the result over. Lookup
// and delete read the key memory one entry per cycle from slot 0 through a
// registered read. A new item is taken as soon as the previous one has moved
// into the output register, even while that result still waits to be taken.
// Keys live in a synchronous memory; slot occupancy is a row of flip-flops
// cleared by reset and by the clear action. Only the lowest min(TABLE_DEPTH,
// 63) slots are ever reachable through the 6-bit table_size register.
module open_addressing_hash_table import oaht_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data,
	// input items
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           action,
	input  logic [KEY_W-1:0]     key,
	// result items
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output logic [SLOT_W-1:0]    slot
);

	localparam int MAX_SIZE  = (1 << SIZE_W) - 1;
	localparam int USE_DEPTH = (TABLE_DEPTH < MAX_SIZE) ? TABLE_DEPTH : MAX_SIZE;
	localparam int IDX_W     = $clog2(USE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [SIZE_W-1:0]    table_size_q;
	logic                 probe_mode_q;
	logic [SIZE_W-1:0]    eff_size;

	logic [KEY_W-1:0]     key_q;
	logic                 del_q;
	logic [SIZE_W-1:0]    size_q;
	logic                 mode_q;
	logic                 start_q;
	logic [SIZE_W-1:0]    idx_q;
	logic [SIZE_W-1:0]    cnt_q;
	logic [SIZE_W-1:0]    sq_q;
	logic [SIZE_W-1:0]    d_q;
	logic [SIZE_W-1:0]    addr_q;
	logic                 hit_q;
	logic [SIZE_W-1:0]    first_q;
	logic [USE_DEPTH-1:0] used_q;

	logic                 rd_valid_s1;
	logic [SIZE_W-1:0]    rd_idx_s1;
	logic [KEY_W-1:0]     key_rd_s1;

	status_t              res_status_q;
	logic [SIZE_W-1:0]    res_slot_q;
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [SLOT_W-1:0]    out_slot_q;

	logic [KEY_W-1:0]     key_mem [USE_DEPTH];

	mod_req_t             mod_req;
	mod_rsp_t             mod_rsp;

	logic                 used_cur;
	logic                 mem_we;
	logic                 scan_hit;
	logic [SIZE_W:0]      step_sum;
	logic [SIZE_W-1:0]    idx_next;
	logic [SIZE_W:0]      sq_sum;
	logic [SIZE_W-1:0]    sq_next;
	logic [SIZE_W:0]      d_sum;
	logic [SIZE_W:0]      d_red;
	logic [SIZE_W-1:0]    d_next;
	logic [SIZE_W-1:0]    sq_init;
	logic [SIZE_W-1:0]    d_init;

	// Saturate the configured size into 1..USE_DEPTH
	always_comb begin
		if (table_size_q == '0)
			eff_size = SIZE_W'(1);
		else if (table_size_q > SIZE_W'(USE_DEPTH))
			eff_size = SIZE_W'(USE_DEPTH);
		else
			eff_size = table_size_q;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= SIZE_W'(32);
			probe_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TABLE_SIZE: table_size_q <= cfg_data;
				CFG_PROBE_MODE: probe_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// Remainder unit for the home slot
	assign mod_req.start = start_q;
	assign mod_req.key   = key_q;
	assign mod_req.size  = size_q;

	oaht_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// Next probe index and the running j*j and 2j+1 terms, all mod size
	always_comb begin
		step_sum = mode_q ? ({1'b0, idx_q} + {1'b0, sq_q}) : ({1'b0, idx_q} + 7'd1);
		idx_next = (step_sum >= {1'b0, size_q}) ? SIZE_W'(step_sum - {1'b0, size_q})
		                                        : SIZE_W'(step_sum);
		sq_sum   = {1'b0, sq_q} + {1'b0, d_q};
		sq_next  = (sq_sum >= {1'b0, size_q}) ? SIZE_W'(sq_sum - {1'b0, size_q})
		                                      : SIZE_W'(sq_sum);
		d_sum    = {1'b0, d_q} + 7'd2;
		d_red    = (d_sum >= {1'b0, size_q}) ? (d_sum - {1'b0, size_q}) : d_sum;
		d_next   = (d_red >= {1'b0, size_q}) ? SIZE_W'(d_red - {1'b0, size_q})
		                                     : SIZE_W'(d_red);
	end

	// Start values for j = 1: 1 mod size and 3 mod size
	always_comb begin
		sq_init = (size_q == SIZE_W'(1)) ? '0 : SIZE_W'(1);
		if (size_q == SIZE_W'(1) || size_q == SIZE_W'(3))
			d_init = '0;
		else if (size_q == SIZE_W'(2))
			d_init = SIZE_W'(1);
		else
			d_init = SIZE_W'(3);
	end

	assign used_cur = used_q[idx_q[IDX_W-1:0]];
	assign mem_we   = (state_q == S_PROBE) && (cnt_q != size_q) && !used_cur;
	assign scan_hit = rd_valid_s1 && used_q[rd_idx_s1[IDX_W-1:0]] && (key_rd_s1 == key_q);

	// Key memory: write on insert, registered read for the scan
	always_ff @(posedge clk) begin
		if (mem_we)
			key_mem[idx_q[IDX_W-1:0]] <= key_q;
		key_rd_s1 <= key_mem[addr_q[IDX_W-1:0]];
	end

	// Sequencer, occupancy bits and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			used_q       <= '0;
			start_q      <= 1'b0;
			rd_valid_s1  <= 1'b0;
			rd_idx_s1    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_CLEARED;
			out_slot_q   <= '0;
			res_status_q <= ST_CLEARED;
			res_slot_q   <= '0;
			key_q        <= '0;
			del_q        <= 1'b0;
			size_q       <= SIZE_W'(1);
			mode_q       <= 1'b0;
			idx_q        <= '0;
			cnt_q        <= '0;
			sq_q         <= '0;
			d_q          <= '0;
			addr_q       <= '0;
			hit_q        <= 1'b0;
			first_q      <= '0;
		end else begin
			rd_valid_s1 <= 1'b0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						key_q  <= key;
						del_q  <= (action_t'(action) == ACT_DELETE);
						size_q <= eff_size;
						mode_q <= probe_mode_q;
						addr_q <= '0;
						hit_q  <= 1'b0;
						first_q <= '0;
						unique case (action_t'(action))
							ACT_CLEAR: begin
								used_q       <= '0;
								res_status_q <= ST_CLEARED;
								res_slot_q   <= '0;
								state_q      <= S_DONE;
							end
							ACT_INSERT: begin
								start_q <= 1'b1;
								state_q <= S_HASH;
							end
							ACT_LOOKUP, ACT_DELETE: begin
								state_q <= S_SCAN;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end

				// wait for the home slot
				S_HASH: begin
					start_q <= 1'b0;
					if (mod_rsp.done) begin
						idx_q   <= mod_rsp.rem;
						cnt_q   <= '0;
						sq_q    <= sq_init;
						d_q     <= d_init;
						state_q <= S_PROBE;
					end
				end

				// probe one slot per cycle
				S_PROBE: begin
					if (cnt_q == size_q) begin
						res_status_q <= ST_FULL;
						res_slot_q   <= '0;
						state_q      <= S_DONE;
					end else if (!used_cur) begin
						used_q[idx_q[IDX_W-1:0]] <= 1'b1;
						res_status_q <= ST_INSERTED;
						res_slot_q   <= idx_q;
						state_q      <= S_DONE;
					end else begin
						idx_q <= idx_next;
						cnt_q <= cnt_q + 1'b1;
						sq_q  <= sq_next;
						d_q   <= d_next;
					end
				end

				// read slots from 0 upward, compare in the next cycle
				S_SCAN: begin
					if (addr_q < size_q) begin
						rd_valid_s1 <= 1'b1;
						addr_q      <= addr_q + 1'b1;
					end
					rd_idx_s1 <= addr_q;
					if (scan_hit) begin
						if (!del_q) begin
							rd_valid_s1  <= 1'b0;
							res_status_q <= ST_FOUND;
							res_slot_q   <= rd_idx_s1;
							state_q      <= S_DONE;
						end else begin
							used_q[rd_idx_s1[IDX_W-1:0]] <= 1'b0;
							if (!hit_q)
								first_q <= rd_idx_s1;
							hit_q <= 1'b1;
						end
					end else if (!rd_valid_s1 && addr_q == size_q) begin
						res_status_q <= hit_q ? ST_DELETED : ST_MISSING;
						res_slot_q   <= hit_q ? first_q : '0;
						state_q      <= S_DONE;
					end
				end

				// hand the result to the output register when it is free
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_slot_q   <= SLOT_W'(res_slot_q);
						state_q      <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign slot      = out_slot_q;

endmodule

### src/oaht_checker.sv
// Port-level checks for open_addressing_hash_table and the bind that attaches them.
// Depends on oaht_pkg.
module oaht_checker import oaht_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [2:0]        status,
	input logic [SLOT_W-1:0] slot
);

	// a stalled result holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot))
		else $error("result item changed while stalled");

	// one item at a time: an accepted item closes the input for the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input still open right after an accepted item");

	// results without a slot report slot zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL || status == ST_MISSING || status == ST_CLEARED)
		|-> slot == '0)
		else $error("nonzero slot on a result without a slot");

	// only defined status codes leave the block
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_CLEARED)
		else $error("undefined status code");

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.slot      (slot)
);
